### rtl/core/sfb_pkg.sv
// Shared types and constants for the stuffed frame builder.
package sfb_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLAG_BYTE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_BYTE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPED_ESC   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPED_FLAG  = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_BYTE  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_EVEN  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_ODD   = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_BIT  = 8'd7;

    // Reset values
    localparam logic [BYTE_W-1:0] RST_FLAG_BYTE    = 8'd126;
    localparam logic [BYTE_W-1:0] RST_ESCAPE_BYTE  = 8'd125;
    localparam logic [BYTE_W-1:0] RST_ESCAPED_ESC  = 8'd93;
    localparam logic [BYTE_W-1:0] RST_ESCAPED_FLAG = 8'd94;
    localparam logic [BYTE_W-1:0] RST_ADDRESS_BYTE = 8'd3;
    localparam logic [BYTE_W-1:0] RST_CONTROL_EVEN = 8'd0;
    localparam logic [BYTE_W-1:0] RST_CONTROL_ODD  = 8'd64;
    localparam logic              RST_SEQUENCE_BIT = 1'b0;

    // Check byte seed at frame start
    localparam logic [BYTE_W-1:0] CHECK_SEED = 8'hff;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              first_byte;
        logic              last_byte;
    } in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] line_byte;
        logic              run_end;
        logic              frame_end;
    } out_t;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_byte;
        logic [BYTE_W-1:0] escape_byte;
        logic [BYTE_W-1:0] escaped_escape;
        logic [BYTE_W-1:0] escaped_flag;
        logic [BYTE_W-1:0] address_byte;
        logic [BYTE_W-1:0] control_even;
        logic [BYTE_W-1:0] control_odd;
        logic              sequence_bit;
    } cfg_t;

    // Classified work item handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] bcc;
        logic              header;
        logic              last;
    } cmd_t;

endpackage

### rtl/core/sfb_front.sv
// Front end: accepts payload bytes, tracks frame state and the running check byte.
module sfb_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sfb_pkg::in_t    in_data,
    input  logic            q_full,
    output logic            push,
    output sfb_pkg::cmd_t   push_cmd
);

    logic [sfb_pkg::BYTE_W-1:0] acc_reg;
    logic [sfb_pkg::BYTE_W-1:0] acc_next;
    logic                       open_reg;
    logic                       open_next;
    logic                       header;
    logic [sfb_pkg::BYTE_W-1:0] acc_base;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        header    = in_data.first_byte || !open_reg;
        acc_base  = header ? sfb_pkg::CHECK_SEED : acc_reg;
        acc_next  = acc_base ^ in_data.payload_byte;
        open_next = !in_data.last_byte;

        push_cmd.data   = in_data.payload_byte;
        push_cmd.bcc    = acc_next;
        push_cmd.header = header;
        push_cmd.last   = in_data.last_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= sfb_pkg::CHECK_SEED;
            open_reg <= 1'b0;
        end
        else if (push)
        begin
            acc_reg  <= acc_next;
            open_reg <= open_next;
        end
    end

endmodule

### rtl/core/sfb_queue.sv
// Short queue of classified items between front and back.
module sfb_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sfb_pkg::cmd_t   push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output sfb_pkg::cmd_t   head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sfb_pkg::cmd_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full  = (cnt_reg == FULL_CNT);
    assign empty = (cnt_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/core/sfb_back.sv
// Back end: walks each frame through header, stuffed data and trailer, one line byte a cycle when not empty or stalled.
module sfb_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  sfb_pkg::cfg_t   cfg,
    input  logic            q_empty,
    input  sfb_pkg::cmd_t   head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output sfb_pkg::out_t   out_data
);

    localparam logic [3:0] ST_START      = 4'd0;
    localparam logic [3:0] ST_FLAG_OPEN  = 4'd1;
    localparam logic [3:0] ST_ADDR       = 4'd2;
    localparam logic [3:0] ST_CTRL       = 4'd3;
    localparam logic [3:0] ST_BCC1       = 4'd4;
    localparam logic [3:0] ST_DATA       = 4'd5;
    localparam logic [3:0] ST_DATA_ESC   = 4'd6;
    localparam logic [3:0] ST_BCC2       = 4'd7;
    localparam logic [3:0] ST_BCC2_ESC   = 4'd8;
    localparam logic [3:0] ST_FLAG_CLOSE = 4'd9;

    logic [3:0]                 step_reg;
    logic [3:0]                 step_next;
    logic [3:0]                 cur;
    logic                       advance;
    logic                       done;
    logic                       fend;
    logic [sfb_pkg::BYTE_W-1:0] byte_val;
    logic [sfb_pkg::BYTE_W-1:0] ctrl;
    logic                       data_esc;
    logic                       data_stuff;
    logic                       bcc_esc;
    logic                       bcc_stuff;
    logic                       out_valid_reg;
    sfb_pkg::out_t              out_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign advance   = !q_empty && (!out_valid_reg || out_ready);
    assign pop       = advance && done;

    always_comb
    begin
        cur = (step_reg == ST_START) ? (head.header ? ST_FLAG_OPEN : ST_DATA) : step_reg;
        ctrl = cfg.sequence_bit ? cfg.control_odd : cfg.control_even;
        // escape match is tested first and wins over flag match
        data_esc   = (head.data == cfg.escape_byte);
        data_stuff = data_esc || (head.data == cfg.flag_byte);
        bcc_esc    = (head.bcc == cfg.escape_byte);
        bcc_stuff  = bcc_esc || (head.bcc == cfg.flag_byte);

        byte_val  = head.data;
        step_next = ST_START;
        done      = 1'b0;
        fend      = 1'b0;
        case (cur)
            ST_FLAG_OPEN:
            begin
                byte_val  = cfg.flag_byte;
                step_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                byte_val  = cfg.address_byte;
                step_next = ST_CTRL;
            end
            ST_CTRL:
            begin
                byte_val  = ctrl;
                step_next = ST_BCC1;
            end
            ST_BCC1:
            begin
                byte_val  = cfg.address_byte ^ ctrl;
                step_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (data_stuff)
                begin
                    byte_val  = cfg.escape_byte;
                    step_next = ST_DATA_ESC;
                end
                else
                begin
                    byte_val  = head.data;
                    step_next = ST_BCC2;
                    done      = !head.last;
                end
            end
            ST_DATA_ESC:
            begin
                byte_val  = data_esc ? cfg.escaped_escape : cfg.escaped_flag;
                step_next = ST_BCC2;
                done      = !head.last;
            end
            ST_BCC2:
            begin
                if (bcc_stuff)
                begin
                    byte_val  = cfg.escape_byte;
                    step_next = ST_BCC2_ESC;
                end
                else
                begin
                    byte_val  = head.bcc;
                    step_next = ST_FLAG_CLOSE;
                end
            end
            ST_BCC2_ESC:
            begin
                byte_val  = bcc_esc ? cfg.escaped_escape : cfg.escaped_flag;
                step_next = ST_FLAG_CLOSE;
            end
            ST_FLAG_CLOSE:
            begin
                byte_val = cfg.flag_byte;
                done     = 1'b1;
                fend     = 1'b1;
            end
            default:
            begin
                byte_val  = head.data;
                step_next = ST_START;
                done      = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                step_reg      <= done ? ST_START : step_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.line_byte <= byte_val;
            out_reg.run_end   <= done;
            out_reg.frame_end <= fend;
        end
    end

endmodule

### rtl/core/stuffed_frame_builder.sv
// Top level of the stuffed frame builder: config registers, front, queue and back.
//
// Input channel (in_valid/in_ready/in_data) takes one payload byte per transaction
// with first/last marks. Output channel (out_valid/out_ready/out_data) gives one
// stuffed line byte per transaction; run_end marks the last byte an input caused,
// frame_end marks the closing flag. The config channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data) writes the marker, address, control and sequence registers;
// it is always ready and should only be used while the block is idle.
// An input byte accepted into an empty block is first written into the queue; its first
// line byte is then registered in the output register. The back end emits one line byte
// per cycle while it has an item and the output is not stalled; an item causes 1 or 2
// line bytes mid-frame, up to 9 with header and trailer. The front keeps accepting while
// the queue of QDEPTH items has room. A stalled receiver holds the output register; the
// back end and then the queue fill, and in_ready drops once the queue is full.
// Reset restores the register defaults, closes any open frame, empties the queue
// and clears the output valid.
module stuffed_frame_builder
#(
    parameter int QDEPTH = 2
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  sfb_pkg::in_t                      in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output sfb_pkg::out_t                     out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sfb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfb_pkg::BYTE_W-1:0]        cfg_data
);

    sfb_pkg::cfg_t cfg_reg;
    sfb_pkg::cmd_t push_cmd;
    sfb_pkg::cmd_t head;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_byte      <= sfb_pkg::RST_FLAG_BYTE;
            cfg_reg.escape_byte    <= sfb_pkg::RST_ESCAPE_BYTE;
            cfg_reg.escaped_escape <= sfb_pkg::RST_ESCAPED_ESC;
            cfg_reg.escaped_flag   <= sfb_pkg::RST_ESCAPED_FLAG;
            cfg_reg.address_byte   <= sfb_pkg::RST_ADDRESS_BYTE;
            cfg_reg.control_even   <= sfb_pkg::RST_CONTROL_EVEN;
            cfg_reg.control_odd    <= sfb_pkg::RST_CONTROL_ODD;
            cfg_reg.sequence_bit   <= sfb_pkg::RST_SEQUENCE_BIT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sfb_pkg::REG_FLAG_BYTE:    cfg_reg.flag_byte      <= cfg_data;
                sfb_pkg::REG_ESCAPE_BYTE:  cfg_reg.escape_byte    <= cfg_data;
                sfb_pkg::REG_ESCAPED_ESC:  cfg_reg.escaped_escape <= cfg_data;
                sfb_pkg::REG_ESCAPED_FLAG: cfg_reg.escaped_flag   <= cfg_data;
                sfb_pkg::REG_ADDRESS_BYTE: cfg_reg.address_byte   <= cfg_data;
                sfb_pkg::REG_CONTROL_EVEN: cfg_reg.control_even   <= cfg_data;
                sfb_pkg::REG_CONTROL_ODD:  cfg_reg.control_odd    <= cfg_data;
                sfb_pkg::REG_SEQUENCE_BIT: cfg_reg.sequence_bit   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    sfb_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    sfb_queue #(.DEPTH(QDEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    sfb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### rtl/core/sfb_checker.sv
// Port-level checker for the stuffed frame builder, bound to the top level.
module sfb_checker
#(
    parameter int QDEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_ready,
    input  logic          out_valid,
    input  logic          out_ready,
    input  sfb_pkg::out_t out_data
);

    localparam int CNT_W = $clog2(QDEPTH + 2) + 1;
    localparam logic [CNT_W-1:0] MAX_PEND = CNT_W'(QDEPTH + 1);

    logic             in_acc;
    logic             run_done;
    logic [CNT_W-1:0] pend_reg;

    assign in_acc   = in_valid && in_ready;
    assign run_done = out_valid && out_ready && out_data.run_end;

    // items accepted whose last line byte has not yet gone out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (in_acc && !run_done)
        begin
            pend_reg <= pend_reg + 1'b1;
        end
        else if (run_done && !in_acc)
        begin
            pend_reg <= pend_reg - 1'b1;
        end
    end

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled output transaction changed");

    a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_end |-> out_data.run_end)
        else $error("closing flag not marked as end of run");

    a_no_phantom_run: assert property (@(posedge clk) disable iff (!rst_n)
        run_done |-> pend_reg != '0)
        else $error("run ended with no input transaction outstanding");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= MAX_PEND)
        else $error("more input transactions in flight than the block can hold");

endmodule

bind stuffed_frame_builder sfb_checker #(.QDEPTH(QDEPTH)) u_sfb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
